FILE: src/voxel_pair_fit_score_accumulator_assert.svh
// Assertion macros used by the checker file of the voxel pair fit score accumulator.
`ifndef VOXEL_PAIR_FIT_SCORE_ACCUMULATOR_ASSERT_SVH
`define VOXEL_PAIR_FIT_SCORE_ACCUMULATOR_ASSERT_SVH

// Checked at every rising edge while reset is released.
`define VPFS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define VPFS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/vpfs_pkg.sv
// Shared types and constants of the voxel pair fit score accumulator.
package vpfs_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 16;
    localparam int SUM_WIDTH_DEFAULT   = 48;
    localparam int QUEUE_DEPTH         = 4;

    localparam int OUT_PEN_W = 47;
    localparam int OUT_CMP_W = 48;
    localparam int MAX_PEN_W = 47;

    localparam logic [MAX_PEN_W-1:0] MAX_PEN_RESET = {MAX_PEN_W{1'b1}};

    typedef logic [2:0] t_cls;

    localparam t_cls CLS_NONE = 3'd0;
    localparam t_cls CLS_CMP  = 3'd1;
    localparam t_cls CLS_PEN  = 3'd2;
    localparam t_cls CLS_BND  = 3'd3;
    localparam t_cls CLS_REJ  = 3'd4;

    typedef struct packed {
        t_cls cls;
        logic last;
    } t_tag;

endpackage

FILE: src/voxel_pair_fit_score_accumulator.sv
// Top level of the voxel pair fit score accumulator.
// Throughput is one voxel pair per cycle while the queue has room; the multiply feeds a four-entry queue.
// The result of a pose passes the queue, the snapshot register and the output register before it appears on o_valid.
// Synchronous active-low reset clears all sums, the queue and the output valid.
// Reset sets the penetration limit to its maximum value.
module voxel_pair_fit_score_accumulator #(
    parameter int VALUE_WIDTH = vpfs_pkg::VALUE_WIDTH_DEFAULT,
    parameter int SUM_WIDTH   = vpfs_pkg::SUM_WIDTH_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [VALUE_WIDTH-1:0]         i_fixed_value,
    input  logic                                  i_fixed_infinite,
    input  logic signed [VALUE_WIDTH-1:0]         i_moved_value,
    input  logic                                  i_moved_infinite,
    input  logic                                  i_last_voxel,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [vpfs_pkg::OUT_PEN_W-1:0]        o_pen_total,
    output logic signed [vpfs_pkg::OUT_CMP_W-1:0] o_cmp_total,
    output logic [vpfs_pkg::OUT_PEN_W-1:0]        o_bnd_total,
    output logic                                  o_rejected,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [vpfs_pkg::MAX_PEN_W-1:0]        i_cfg_max_penetration
);
    import vpfs_pkg::*;

    localparam int PW = 2 * VALUE_WIDTH;
    localparam int QW = $bits(t_tag) + PW;

    logic                 w_push_valid;
    logic                 w_push_ready;
    t_tag                 w_front_tag;
    logic signed [PW-1:0] w_front_product;
    logic                 w_pop_valid;
    logic                 w_pop_ready;
    logic [QW-1:0]        w_pop_data;
    t_tag                 w_back_tag;
    logic signed [PW-1:0] w_back_product;

    vpfs_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_fixed_value   (i_fixed_value),
        .i_fixed_infinite(i_fixed_infinite),
        .i_moved_value   (i_moved_value),
        .i_moved_infinite(i_moved_infinite),
        .i_last_voxel    (i_last_voxel),
        .o_push_valid    (w_push_valid),
        .i_push_ready    (w_push_ready),
        .o_tag           (w_front_tag),
        .o_product       (w_front_product)
    );

    vpfs_queue #(
        .WIDTH(QW),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(w_push_valid),
        .o_push_ready(w_push_ready),
        .i_push_data ({w_front_tag, w_front_product}),
        .o_pop_valid (w_pop_valid),
        .i_pop_ready (w_pop_ready),
        .o_pop_data  (w_pop_data)
    );

    assign w_back_tag     = w_pop_data[QW-1:PW];
    assign w_back_product = $signed(w_pop_data[PW-1:0]);

    vpfs_back #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .SUM_WIDTH  (SUM_WIDTH)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_pop_valid          (w_pop_valid),
        .o_pop_ready          (w_pop_ready),
        .i_tag                (w_back_tag),
        .i_product            (w_back_product),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_max_penetration(i_cfg_max_penetration),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_pen_total          (o_pen_total),
        .o_cmp_total          (o_cmp_total),
        .o_bnd_total          (o_bnd_total),
        .o_rejected           (o_rejected)
    );

endmodule

FILE: src/vpfs_queue.sv
// Short register queue between the classifying front and the accumulating back.
module vpfs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output logic [WIDTH-1:0] o_pop_data
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [AW:0]      r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != (AW+1)'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

FILE: src/vpfs_front.sv
// Front part: takes voxel pairs, multiplies them and classifies each pair.
module vpfs_front #(
    parameter int VALUE_WIDTH = vpfs_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_fixed_value,
    input  logic                          i_fixed_infinite,
    input  logic signed [VALUE_WIDTH-1:0] i_moved_value,
    input  logic                          i_moved_infinite,
    input  logic                          i_last_voxel,
    output logic                          o_push_valid,
    input  logic                          i_push_ready,
    output vpfs_pkg::t_tag                o_tag,
    output logic signed [2*VALUE_WIDTH-1:0] o_product
);
    import vpfs_pkg::*;

    logic w_fixed_pos;
    logic w_moved_pos;
    logic w_fixed_neg;
    logic w_moved_neg;
    logic w_inf_any;
    t_cls w_cls;

    assign o_ready      = i_push_ready;
    assign o_push_valid = i_valid;
    assign o_product    = i_fixed_value * i_moved_value;

    assign w_fixed_neg = i_fixed_value[VALUE_WIDTH-1];
    assign w_moved_neg = i_moved_value[VALUE_WIDTH-1];
    assign w_fixed_pos = i_fixed_infinite || (!w_fixed_neg && (i_fixed_value != '0));
    assign w_moved_pos = i_moved_infinite || (!w_moved_neg && (i_moved_value != '0));
    assign w_inf_any   = i_fixed_infinite || i_moved_infinite;

    always_comb begin
        if (w_fixed_pos && w_moved_pos && w_inf_any) begin
            w_cls = CLS_REJ;
        end else if (w_inf_any || (i_fixed_value == '0) || (i_moved_value == '0)) begin
            w_cls = CLS_NONE;
        end else if (w_fixed_pos && w_moved_pos) begin
            w_cls = CLS_PEN;
        end else if (w_fixed_neg && w_moved_neg) begin
            w_cls = CLS_BND;
        end else begin
            w_cls = CLS_CMP;
        end
    end

    assign o_tag.cls  = w_cls;
    assign o_tag.last = i_last_voxel;

endmodule

FILE: src/vpfs_back.sv
// Back part: saturating accumulation, pose result capture and the output register.
module vpfs_back #(
    parameter int VALUE_WIDTH = vpfs_pkg::VALUE_WIDTH_DEFAULT,
    parameter int SUM_WIDTH   = vpfs_pkg::SUM_WIDTH_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_pop_valid,
    output logic                                  o_pop_ready,
    input  vpfs_pkg::t_tag                        i_tag,
    input  logic signed [2*VALUE_WIDTH-1:0]       i_product,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [vpfs_pkg::MAX_PEN_W-1:0]        i_cfg_max_penetration,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [vpfs_pkg::OUT_PEN_W-1:0]        o_pen_total,
    output logic signed [vpfs_pkg::OUT_CMP_W-1:0] o_cmp_total,
    output logic [vpfs_pkg::OUT_PEN_W-1:0]        o_bnd_total,
    output logic                                  o_rejected
);
    import vpfs_pkg::*;

    localparam int PW = 2 * VALUE_WIDTH;
    localparam int AW = ((SUM_WIDTH > PW) ? SUM_WIDTH : PW) + 1;
    localparam int CW = (SUM_WIDTH > OUT_CMP_W) ? SUM_WIDTH : OUT_CMP_W;
    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    logic [MAX_PEN_W-1:0]        r_max_pen;
    logic signed [SUM_WIDTH-1:0] r_pen, n_pen;
    logic signed [SUM_WIDTH-1:0] r_cmp, n_cmp;
    logic signed [SUM_WIDTH-1:0] r_bnd, n_bnd;
    logic                        r_rej, n_rej;

    logic                        r_snap_valid, n_snap_valid;
    logic signed [SUM_WIDTH-1:0] r_snap_pen;
    logic signed [SUM_WIDTH-1:0] r_snap_cmp;
    logic signed [SUM_WIDTH-1:0] r_snap_bnd;
    logic                        r_snap_rej;

    logic                        r_o_valid;
    logic [OUT_PEN_W-1:0]        r_o_pen, n_o_pen;
    logic signed [OUT_CMP_W-1:0] r_o_cmp, n_o_cmp;
    logic [OUT_PEN_W-1:0]        r_o_bnd, n_o_bnd;
    logic                        r_o_rej, n_o_rej;

    logic                        w_out_ready;
    logic                        w_snap_ready;
    logic                        w_pop;
    logic signed [SUM_WIDTH-1:0] w_sel;
    logic signed [AW-1:0]        w_sum;
    logic signed [SUM_WIDTH-1:0] w_new;

    logic signed [CW-1:0]        w_pen_x;
    logic signed [CW-1:0]        w_cmp_x;
    logic signed [CW-1:0]        w_bnd_x;
    logic signed [CW-1:0]        w_lim;
    logic signed [CW-1:0]        w_pen_max;
    logic signed [CW-1:0]        w_cmp_min;
    logic                        w_reject;

    assign o_cfg_ready  = 1'b1;
    assign w_out_ready  = !r_o_valid || i_ready;
    assign w_snap_ready = !r_snap_valid || w_out_ready;
    assign o_pop_ready  = w_snap_ready;
    assign w_pop        = i_pop_valid && w_snap_ready;

    always_comb begin
        case (i_tag.cls)
            CLS_PEN: w_sel = r_pen;
            CLS_BND: w_sel = r_bnd;
            default: w_sel = r_cmp;
        endcase
    end

    assign w_sum = AW'(w_sel) + AW'(i_product);

    always_comb begin
        if (w_sum > AW'(SUM_MAX)) begin
            w_new = SUM_MAX;
        end else if (w_sum < AW'(SUM_MIN)) begin
            w_new = SUM_MIN;
        end else begin
            w_new = w_sum[SUM_WIDTH-1:0];
        end
    end

    always_comb begin
        n_pen = r_pen;
        n_cmp = r_cmp;
        n_bnd = r_bnd;
        n_rej = r_rej;
        if (w_pop) begin
            case (i_tag.cls)
                CLS_PEN: n_pen = w_new;
                CLS_BND: n_bnd = w_new;
                CLS_CMP: n_cmp = w_new;
                CLS_REJ: n_rej = 1'b1;
                default: n_rej = r_rej;
            endcase
        end
    end

    always_comb begin
        if (w_pop && i_tag.last) begin
            n_snap_valid = 1'b1;
        end else if (w_out_ready) begin
            n_snap_valid = 1'b0;
        end else begin
            n_snap_valid = r_snap_valid;
        end
    end

    // The penetration sum never falls, so a final sum above the limit means it was crossed.
    assign w_pen_x   = CW'(r_snap_pen);
    assign w_cmp_x   = CW'(r_snap_cmp);
    assign w_bnd_x   = CW'(r_snap_bnd);
    assign w_lim     = $signed(CW'(r_max_pen));
    assign w_pen_max = $signed(CW'({OUT_PEN_W{1'b1}}));
    assign w_cmp_min = ~w_pen_max;
    assign w_reject  = r_snap_rej || (w_pen_x > w_lim);

    always_comb begin
        if (w_reject) begin
            n_o_pen = {OUT_PEN_W{1'b1}};
            n_o_cmp = '0;
            n_o_bnd = {OUT_PEN_W{1'b1}};
            n_o_rej = 1'b1;
        end else begin
            n_o_pen = (w_pen_x > w_pen_max) ? w_pen_max[OUT_PEN_W-1:0] : w_pen_x[OUT_PEN_W-1:0];
            n_o_cmp = (w_cmp_x < w_cmp_min) ? w_cmp_min[OUT_CMP_W-1:0] : w_cmp_x[OUT_CMP_W-1:0];
            n_o_bnd = (w_bnd_x > w_pen_max) ? w_pen_max[OUT_PEN_W-1:0] : w_bnd_x[OUT_PEN_W-1:0];
            n_o_rej = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pen    <= MAX_PEN_RESET;
            r_pen        <= '0;
            r_cmp        <= '0;
            r_bnd        <= '0;
            r_rej        <= 1'b0;
            r_snap_valid <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max_pen <= i_cfg_max_penetration;
            end
            if (w_pop && i_tag.last) begin
                r_pen <= '0;
                r_cmp <= '0;
                r_bnd <= '0;
                r_rej <= 1'b0;
            end else begin
                r_pen <= n_pen;
                r_cmp <= n_cmp;
                r_bnd <= n_bnd;
                r_rej <= n_rej;
            end
            r_snap_valid <= n_snap_valid;
            if (w_out_ready) begin
                r_o_valid <= r_snap_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && i_tag.last) begin
            r_snap_pen <= n_pen;
            r_snap_cmp <= n_cmp;
            r_snap_bnd <= n_bnd;
            r_snap_rej <= n_rej;
        end
        if (w_out_ready && r_snap_valid) begin
            r_o_pen <= n_o_pen;
            r_o_cmp <= n_o_cmp;
            r_o_bnd <= n_o_bnd;
            r_o_rej <= n_o_rej;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_pen_total = r_o_pen;
    assign o_cmp_total = r_o_cmp;
    assign o_bnd_total = r_o_bnd;
    assign o_rejected  = r_o_rej;

endmodule

FILE: src/vpfs_checker.sv
// Port checker of the voxel pair fit score accumulator and its bind.
`include "voxel_pair_fit_score_accumulator_assert.svh"

module vpfs_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_valid,
    input logic                                  i_ready,
    input logic [vpfs_pkg::OUT_PEN_W-1:0]        o_pen_total,
    input logic signed [vpfs_pkg::OUT_CMP_W-1:0] o_cmp_total,
    input logic [vpfs_pkg::OUT_PEN_W-1:0]        o_bnd_total,
    input logic                                  o_rejected
);
    import vpfs_pkg::*;

    `VPFS_ASSERT(a_result_held, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid, "Result item dropped.")
    `VPFS_ASSERT(a_reject_fields, i_clk, i_rst_n, o_valid && o_rejected |-> (o_cmp_total == '0) && (&o_pen_total) && (&o_bnd_total), "Rejected result fields wrong.")
    `VPFS_ASSERT(a_cmp_not_positive, i_clk, i_rst_n, o_valid |-> o_cmp_total[OUT_CMP_W-1] || (o_cmp_total == '0), "Positive total.")
    `VPFS_ASSERT_ALWAYS(a_reset_clears_valid, i_clk, !i_rst_n |=> !o_valid, "Result valid after reset.")

endmodule

bind voxel_pair_fit_score_accumulator vpfs_checker u_vpfs_checker (.*);
